[sv/rcr_pkg.sv]
// Shared types, constants and command codes of the range encoder.
`timescale 1ns / 1ps
package rcr_pkg;

   localparam int PENDING_BITS_DEF = 32;

   localparam logic [31:0] RC_BOTTOM   = 32'h0080_0000;
   localparam logic [31:0] RC_TOP      = 32'h8000_0000;
   localparam logic [31:0] RC_FF_LIMIT = 32'h7f80_0000;
   localparam logic [31:0] UNI_SPLIT   = 32'd4194303;
   localparam logic [5:0]  BITS_SPLIT  = 6'd21;
   localparam logic [4:0]  PART_BITS   = 5'd16;
   localparam logic [31:0] FIN_SHIFT   = 32'd5;

   typedef enum logic [1:0] {
      CMD_SYMBOL  = 2'd0,
      CMD_BITS    = 2'd1,
      CMD_UNIFORM = 2'd2,
      CMD_FINISH  = 2'd3
   } op_type;

   // finish emits, in stream order
   localparam logic [2:0] FIN_HELD = 3'd0;
   localparam logic [2:0] FIN_TAIL = 3'd1;
   localparam logic [2:0] FIN_SC2  = 3'd2;
   localparam logic [2:0] FIN_SC1  = 3'd3;
   localparam logic [2:0] FIN_SC0  = 3'd4;

   typedef struct packed {
      op_type      cmd;
      logic [31:0] value;
      logic [15:0] cum_freq;
      logic [16:0] sym_freq;
      logic [4:0]  total_bits;
      logic [5:0]  bit_count;
      logic [31:0] divisor;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [31:0] follow_count;
      logic        follow_is_ones;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       pass;
      logic       renorm;
      logic       rcalc;
      logic       div_init;
      logic       div_step;
      logic       mul_a;
      logic       mul_b;
      logic       update;
      logic       fin_add;
      logic       fin_emit;
      logic [2:0] fin_idx;
      logic       flush;
   } ctl_type;

   typedef struct packed {
      logic split;
      logic udiv;
      logic is_finish;
      logic need_renorm;
      logic renorm_emits;
      logic can_emit;
   } sts_type;

endpackage

[sv/range_encoder_carry_resolving.sv]
// Top level of the carry-resolving range encoder.
//
//  channel | ports                          | beat
//  --------+--------------------------------+------------------------------
//  request | req_valid req_ready req_data   | one command with operands
//  result  | rsp_valid rsp_ready rsp_data   | one byte plus its follow run
//  config  | csr_valid csr_ready csr_data   | header byte
//
// One command at a time. The final pass of a uniform command runs a radix-2
// divider before its multiply. Split raw or uniform commands run two passes.
// Results go through a one-beat stage and an output register so the last beat
// of a command is known; a stalled result channel holds emitting steps only.
// Synchronous reset; no clearing pass is needed.
`timescale 1ns / 1ps
module range_encoder_carry_resolving import rcr_pkg::*; #(
   parameter int PENDING_COUNT_BITS = PENDING_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   ctl_type ctl;
   sts_type sts;

   assign csr_ready = 1'b1;

   rcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (sts),
      .cmd       (ctl)
   );

   rcr_dp #(.PENDING_COUNT_BITS(PENDING_COUNT_BITS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wr    (csr_valid & csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (ctl),
      .status    (sts)
   );

endmodule

[sv/rcr_ctrl.sv]
// Sequencer of the range encoder: renormalize, divide or shift, multiply, update, emit.
`timescale 1ns / 1ps
module rcr_ctrl import rcr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type status,
   output ctl_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_RENORM, S_DIV, S_MUL_A, S_MUL_B, S_UPD,
      S_FADD, S_FEMIT, S_FLUSH
   } state_type;

   state_type  state_ff, state_in;
   logic       pass_ff, pass_in;
   logic [4:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      pass_in   = pass_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      cmd.pass  = pass_ff;
      cmd.fin_idx = cnt_ff[2:0];
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            pass_in  = status.is_finish | ~status.split;
            state_in = S_RENORM;
         end
         S_RENORM: begin
            if (status.need_renorm) begin
               // stall an emitting step until the staged beat can move on
               cmd.renorm = ~status.renorm_emits | status.can_emit;
            end else if (status.is_finish) begin
               state_in = S_FADD;
            end else if (pass_ff && status.udiv) begin
               cmd.div_init = 1'b1;
               cnt_in   = '0;
               state_in = S_DIV;
            end else begin
               cmd.rcalc = 1'b1;
               state_in  = S_MUL_A;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) state_in = S_MUL_A;
         end
         S_MUL_A: begin
            cmd.mul_a = 1'b1;
            state_in  = S_MUL_B;
         end
         S_MUL_B: begin
            cmd.mul_b = 1'b1;
            state_in  = S_UPD;
         end
         S_UPD: begin
            cmd.update = 1'b1;
            if (!pass_ff) begin
               pass_in  = 1'b1;
               state_in = S_RENORM;
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_FADD: begin
            cmd.fin_add = 1'b1;
            cnt_in   = '0;
            state_in = S_FEMIT;
         end
         S_FEMIT: begin
            if (status.can_emit) begin
               cmd.fin_emit = 1'b1;
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff[2:0] == FIN_SC0) state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (status.can_emit) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[sv/rcr_dp.sv]
// Datapath of the range encoder: interval, carry state, divider, multiplier, output stage.
`timescale 1ns / 1ps
module rcr_dp import rcr_pkg::*; #(
   parameter int PENDING_COUNT_BITS = PENDING_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  logic    csr_wr,
   input  logic [7:0] csr_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  ctl_type cmd,
   output sts_type status
);

   localparam logic [PENDING_COUNT_BITS-1:0] PEND_MAX = '1;

   logic [31:0] low_ff, low_in, range_ff, range_in, shift_ff, shift_in;
   logic [7:0]  held_ff, held_in;
   logic [PENDING_COUNT_BITS-1:0] pend_ff, pend_in;
   logic        fresh_ff, fresh_in;

   op_type      op_ff;
   logic        split_ff, full0_ff, full1_ff;
   logic [15:0] a0_ff;
   logic [21:0] a1_ff, div1_ff;
   logic [4:0]  k1_ff;
   logic [16:0] f1_ff;

   logic [31:0] r_ff, tmp_ff, rf_ff;
   logic [21:0] rem_ff;
   logic [9:0]  t_ff;

   rsp_type stage_ff, rsp_ff;
   logic    stage_vld_ff, rsp_vld_ff;

   // operand conditioning at load
   logic [4:0]  lg_s;
   logic [16:0] tot, cum_s, fr0, fr_s;
   logic [17:0] sum0;
   logic        full_sym;
   logic [5:0]  bs;
   logic [31:0] vm;
   logic        split_b, full_b;
   logic [20:0] a1b;
   logic [4:0]  k1b;
   logic [31:0] dv, vs;
   logic        split_u, full_u;
   logic [21:0] a1u, div1u;

   always_comb begin
      lg_s = req_data.total_bits;
      if (req_data.total_bits == 5'd0) lg_s = 5'd1;
      else if (req_data.total_bits > 5'd16) lg_s = 5'd16;
      tot   = 17'd1 << lg_s;
      cum_s = ({1'b0, req_data.cum_freq} >= tot) ? tot - 17'd1 : {1'b0, req_data.cum_freq};
      fr0   = (req_data.sym_freq == 17'd0) ? 17'd1 : req_data.sym_freq;
      sum0  = {1'b0, cum_s} + {1'b0, fr0};
      fr_s  = (sum0 > {1'b0, tot}) ? tot - cum_s : fr0;
      full_sym = (sum0 >= {1'b0, tot});

      bs = req_data.bit_count;
      if (req_data.bit_count == 6'd0) bs = 6'd1;
      else if (req_data.bit_count > 6'd32) bs = 6'd32;
      vm      = req_data.value & 32'((33'd1 << bs) - 33'd1);
      split_b = (bs > BITS_SPLIT);
      a1b     = split_b ? {5'd0, vm[31:16]} : vm[20:0];
      k1b     = split_b ? 5'(bs - 6'd16) : 5'(bs);
      full_b  = ({1'b0, a1b} == 22'((23'd1 << k1b) - 23'd1));

      dv      = (req_data.divisor == 32'd0) ? 32'd1 : req_data.divisor;
      vs      = (req_data.value >= dv) ? dv - 32'd1 : req_data.value;
      split_u = (dv > UNI_SPLIT);
      a1u     = split_u ? {6'd0, vs[31:16]} : vs[21:0];
      div1u   = split_u ? 22'(dv[31:16]) + 22'd1 : dv[21:0];
      full_u  = ({1'b0, a1u} + 23'd1) >= {1'b0, div1u};
   end

   // operands of the current pass
   logic [21:0] a_x, mb;
   logic [4:0]  k_x;
   logic [16:0] f_x;
   logic        full_x;
   logic [53:0] prod;

   assign a_x    = cmd.pass ? a1_ff : {6'd0, a0_ff};
   assign k_x    = cmd.pass ? k1_ff : PART_BITS;
   assign f_x    = cmd.pass ? f1_ff : 17'd1;
   assign full_x = cmd.pass ? full1_ff : full0_ff;
   assign mb     = cmd.mul_b ? {5'd0, f_x} : a_x;
   assign prod   = r_ff * mb;

   // divider step
   logic [22:0] rem_sh;
   logic        rem_ge;
   assign rem_sh = {rem_ff, r_ff[31]};
   assign rem_ge = (rem_sh >= {1'b0, div1_ff});

   // renormalization and emits
   logic    low_small, carry_r, out_free, emit_go;
   logic    e_ones, e_pend;
   logic [7:0] e_byte;
   logic [31:0] shift_n;
   rsp_type e_res, push_res;
   logic    push;

   assign low_small = (low_ff < RC_FF_LIMIT);
   assign carry_r   = low_ff[31];
   assign out_free  = ~rsp_vld_ff | rsp_ready;
   assign shift_n   = shift_ff + FIN_SHIFT;

   always_comb begin
      e_pend = 1'b0;
      e_ones = 1'b0;
      e_byte = t_ff[7:0];
      if (cmd.renorm) begin
         e_pend = 1'b1;
         e_ones = low_small;
         e_byte = low_small ? held_ff : held_ff + 8'd1;
      end else begin
         case (cmd.fin_idx)
            FIN_HELD: begin
               e_pend = 1'b1;
               e_ones = (t_ff[9:8] == 2'd0);
               e_byte = e_ones ? held_ff : held_ff + 8'd1;
            end
            FIN_TAIL: e_byte = t_ff[7:0];
            FIN_SC2:  e_byte = shift_ff[23:16];
            FIN_SC1:  e_byte = shift_ff[15:8];
            FIN_SC0:  e_byte = shift_ff[7:0];
            default:  e_byte = t_ff[7:0];
         endcase
      end
      e_res.out_byte       = e_byte;
      e_res.follow_count   = e_pend ? 32'(pend_ff) : 32'd0;
      e_res.follow_is_ones = e_pend && (pend_ff != '0) && e_ones;
      e_res.last           = 1'b0;
   end

   assign emit_go = (cmd.renorm & (low_small | carry_r)) | cmd.fin_emit;
   assign push    = (emit_go | cmd.flush) & stage_vld_ff;
   always_comb begin
      push_res      = stage_ff;
      push_res.last = cmd.flush;
   end

   always_comb begin
      low_in   = low_ff;
      range_in = range_ff;
      shift_in = shift_ff;
      held_in  = held_ff;
      pend_in  = pend_ff;
      fresh_in = fresh_ff;
      if (csr_wr && fresh_ff) held_in = csr_data;
      if (cmd.renorm) begin
         if (low_small || carry_r) begin
            pend_in = '0;
            held_in = low_ff[30:23];
         end else if (pend_ff != PEND_MAX) begin
            pend_in = pend_ff + 1'b1;
         end
         range_in = range_ff << 8;
         low_in   = (low_ff << 8) & (RC_TOP - 32'd1);
         shift_in = shift_ff + 32'd1;
         fresh_in = 1'b0;
      end
      if (cmd.update) begin
         low_in   = low_ff + tmp_ff;
         range_in = full_x ? range_ff - tmp_ff : rf_ff;
      end
      if (cmd.fin_add) begin
         shift_in = shift_n;
         fresh_in = 1'b0;
      end
      if (cmd.fin_emit && cmd.fin_idx == FIN_HELD) pend_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= '0;
         range_ff     <= RC_TOP;
         shift_ff     <= '0;
         held_ff      <= '0;
         pend_ff      <= '0;
         fresh_ff     <= 1'b1;
         stage_vld_ff <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         low_ff   <= low_in;
         range_ff <= range_in;
         shift_ff <= shift_in;
         held_ff  <= held_in;
         pend_ff  <= pend_in;
         fresh_ff <= fresh_in;
         if (emit_go) stage_vld_ff <= 1'b1;
         else if (cmd.flush) stage_vld_ff <= 1'b0;
         if (push) rsp_vld_ff <= 1'b1;
         else if (rsp_ready) rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_data.cmd;
         split_ff <= ((req_data.cmd == CMD_BITS) && split_b) ||
                     ((req_data.cmd == CMD_UNIFORM) && split_u);
         a0_ff    <= (req_data.cmd == CMD_BITS) ? vm[15:0] : vs[15:0];
         full0_ff <= ((req_data.cmd == CMD_BITS) ? vm[15:0] : vs[15:0]) == 16'hffff;
         div1_ff  <= div1u;
         case (req_data.cmd)
            CMD_SYMBOL: begin
               a1_ff    <= {6'd0, cum_s[15:0]};
               k1_ff    <= lg_s;
               f1_ff    <= fr_s;
               full1_ff <= full_sym;
            end
            CMD_BITS: begin
               a1_ff    <= {1'b0, a1b};
               k1_ff    <= k1b;
               f1_ff    <= 17'd1;
               full1_ff <= full_b;
            end
            default: begin
               a1_ff    <= a1u;
               k1_ff    <= 5'd0;
               f1_ff    <= 17'd1;
               full1_ff <= full_u;
            end
         endcase
      end
      if (cmd.rcalc) r_ff <= range_ff >> k_x;
      if (cmd.div_init) begin
         r_ff   <= range_ff;
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         // quotient bits shift in where dividend bits leave
         rem_ff <= rem_ge ? 22'(rem_sh - {1'b0, div1_ff}) : rem_sh[21:0];
         r_ff   <= {r_ff[30:0], rem_ge};
      end
      if (cmd.mul_a) tmp_ff <= prod[31:0];
      if (cmd.mul_b) rf_ff  <= prod[31:0];
      if (cmd.fin_add) begin
         t_ff <= ({1'b0, low_ff[22:0]} < (shift_n[23:0] >> 1)) ?
                 {1'b0, low_ff[31:23]} : {1'b0, low_ff[31:23]} + 10'd1;
      end
      if (emit_go) stage_ff <= e_res;
      if (push) rsp_ff <= push_res;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   assign status.split        = split_ff;
   assign status.udiv         = (op_ff == CMD_UNIFORM);
   assign status.is_finish    = (op_ff == CMD_FINISH);
   assign status.need_renorm  = (range_ff <= RC_BOTTOM);
   assign status.renorm_emits = low_small | carry_r;
   assign status.can_emit     = ~stage_vld_ff | out_free;

endmodule

[sv/rcr_checker.sv]
// Port-level checks of the range encoder, bound to the top level.
`timescale 1ns / 1ps
module rcr_checker import rcr_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_rst_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second command taken while busy");

   a_follow_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.follow_is_ones && rsp_data.follow_count == 32'd0))
      else $error("follow kind set with empty run");

endmodule

bind range_encoder_carry_resolving rcr_checker u_chk (.*);
